// File: sv/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg: shared constants for the RV32I executor
// Opcodes, function codes, access sizes and pc constants.
// ----------------------------------------------------------------------------
`default_nettype none
package rvx_pkg;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;

	localparam logic [6:0] F7_NORM = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	localparam logic [31:0] JALR_MASK = 32'hFFFF_FFFE;
	localparam logic [31:0] PC_STEP   = 32'h4;
endpackage
`default_nettype wire

// File: sv/rv32i_instruction_executor_unit.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_executor_unit: RV32I single-issue executor
// An accepted word is held in stage 1 (register read), then executed into the result register.
// Throughput: one word per cycle while out_stall is low; each result is forwarded
// into the register read of the next, so dependent words still go back to back.
// Reset: pc clears to zero, all registers read zero (per-entry valid bits),
// no word in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32i_instruction_executor_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// start address register
	input  wire logic        start_address_we,
	input  wire logic [31:0] start_address,
	// instruction channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] instr_word,
	input  wire logic [31:0] load_word,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      next_pc,
	output logic             mem_read,
	output logic             mem_write,
	output logic [31:0]      mem_addr,
	output logic [1:0]       mem_size,
	output logic [31:0]      store_word,
	output logic             reg_write,
	output logic [4:0]       reg_index,
	output logic [31:0]      reg_value,
	output logic             bad_encoding
);
	// Stage 1 holds the accepted word plus its operands read from the file.
	logic        valid_s1;
	logic [31:0] instr_s1, load_s1, a_s1, b_s1;
	logic [31:0] pc_q;
	logic [31:0] regs [32];
	logic [31:0] rvalid_q;
	logic        adv, acc;

	// execute results (combinational from stage 1)
	logic [31:0] npc, maddr, sword, val;
	logic [1:0]  msize;
	logic        mrd, mwr, wr, bad;
	logic [4:0]  rd;

	logic [6:0]  opc, f7;
	logic [2:0]  f3;
	logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, seq, opb;
	logic        slt_r, sltu_r, take;

	// Stage 1 moves on when the result register is free or being drained.
	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign acc      = in_valid && !in_stall;

	always_comb begin
		opc   = instr_s1[6:0];
		f3    = instr_s1[14:12];
		f7    = instr_s1[31:25];
		imm_i = {{20{instr_s1[31]}}, instr_s1[31:20]};
		imm_s = {{20{instr_s1[31]}}, instr_s1[31:25], instr_s1[11:7]};
		imm_b = {{20{instr_s1[31]}}, instr_s1[7], instr_s1[30:25], instr_s1[11:8], 1'b0};
		imm_u = {instr_s1[31:12], 12'd0};
		imm_j = {{12{instr_s1[31]}}, instr_s1[19:12], instr_s1[20], instr_s1[30:21], 1'b0};
		seq   = pc_q + rvx_pkg::PC_STEP;
		opb   = (opc == rvx_pkg::OP_REG) ? b_s1 : imm_i;
		slt_r  = $signed(a_s1) < $signed(opb);
		sltu_r = a_s1 < opb;
		npc = seq; maddr = '0; msize = rvx_pkg::SIZE_BYTE; sword = '0; val = '0;
		mrd = 1'b0; mwr = 1'b0; wr = 1'b0; bad = 1'b0; take = 1'b0;
		unique case (opc)
			rvx_pkg::OP_BRANCH: begin
				case (f3)
					rvx_pkg::F3_BEQ:  take = (a_s1 == b_s1);
					rvx_pkg::F3_BNE:  take = (a_s1 != b_s1);
					rvx_pkg::F3_BLT:  take = $signed(a_s1) < $signed(b_s1);
					rvx_pkg::F3_BGE:  take = !($signed(a_s1) < $signed(b_s1));
					rvx_pkg::F3_BLTU: take = a_s1 < b_s1;
					rvx_pkg::F3_BGEU: take = !(a_s1 < b_s1);
					default:          bad = 1'b1;
				endcase
				if (take) npc = pc_q + imm_b;
			end
			rvx_pkg::OP_JAL: begin
				npc = pc_q + imm_j; wr = 1'b1; val = seq;
			end
			rvx_pkg::OP_JALR: begin
				if (f3 != 3'd0) bad = 1'b1;
				npc = (a_s1 + imm_i) & rvx_pkg::JALR_MASK; wr = 1'b1; val = seq;
			end
			rvx_pkg::OP_LOAD: begin
				maddr = a_s1 + imm_i; mrd = 1'b1; wr = 1'b1;
				case (f3)
					rvx_pkg::F3_LB: begin
						msize = rvx_pkg::SIZE_BYTE; val = {{24{load_s1[7]}}, load_s1[7:0]};
					end
					rvx_pkg::F3_LH: begin
						msize = rvx_pkg::SIZE_HALF; val = {{16{load_s1[15]}}, load_s1[15:0]};
					end
					rvx_pkg::F3_LW: begin
						msize = rvx_pkg::SIZE_WORD; val = load_s1;
					end
					rvx_pkg::F3_LBU: begin
						msize = rvx_pkg::SIZE_BYTE; val = {24'd0, load_s1[7:0]};
					end
					rvx_pkg::F3_LHU: begin
						msize = rvx_pkg::SIZE_HALF; val = {16'd0, load_s1[15:0]};
					end
					default: bad = 1'b1;
				endcase
			end
			rvx_pkg::OP_STORE: begin
				if (f3 > 3'd2) bad = 1'b1;
				maddr = a_s1 + imm_s; mwr = 1'b1; msize = f3[1:0]; sword = b_s1;
			end
			rvx_pkg::OP_REG, rvx_pkg::OP_IMM: begin
				wr = 1'b1;
				case (f3)
					rvx_pkg::F3_ADD: begin
						if (opc == rvx_pkg::OP_IMM || f7 == rvx_pkg::F7_NORM) val = a_s1 + opb;
						else if (f7 == rvx_pkg::F7_ALT) val = a_s1 - opb;
						else bad = 1'b1;
					end
					rvx_pkg::F3_SLL: begin
						if (f7 == rvx_pkg::F7_NORM) val = a_s1 << opb[4:0];
						else bad = 1'b1;
					end
					rvx_pkg::F3_SLT: begin
						val = {31'd0, slt_r};
						if (opc == rvx_pkg::OP_REG && f7 != rvx_pkg::F7_NORM) bad = 1'b1;
					end
					rvx_pkg::F3_SLTU: begin
						val = {31'd0, sltu_r};
						if (opc == rvx_pkg::OP_REG && f7 != rvx_pkg::F7_NORM) bad = 1'b1;
					end
					rvx_pkg::F3_XOR: begin
						val = a_s1 ^ opb;
						if (opc == rvx_pkg::OP_REG && f7 != rvx_pkg::F7_NORM) bad = 1'b1;
					end
					rvx_pkg::F3_SR: begin
						if (f7 == rvx_pkg::F7_NORM) val = a_s1 >> opb[4:0];
						else if (f7 == rvx_pkg::F7_ALT) val = $unsigned($signed(a_s1) >>> opb[4:0]);
						else bad = 1'b1;
					end
					rvx_pkg::F3_OR: begin
						val = a_s1 | opb;
						if (opc == rvx_pkg::OP_REG && f7 != rvx_pkg::F7_NORM) bad = 1'b1;
					end
					default: begin
						val = a_s1 & opb;
						if (opc == rvx_pkg::OP_REG && f7 != rvx_pkg::F7_NORM) bad = 1'b1;
					end
				endcase
			end
			rvx_pkg::OP_LUI: begin
				wr = 1'b1; val = imm_u;
			end
			rvx_pkg::OP_AUIPC: begin
				wr = 1'b1; val = pc_q + imm_u;
			end
			default: bad = 1'b1;
		endcase
		if (bad) begin
			npc = pc_q; maddr = '0; msize = rvx_pkg::SIZE_BYTE; sword = '0; val = '0;
			mrd = 1'b0; mwr = 1'b0; wr = 1'b0;
		end
		rd = wr ? instr_s1[11:7] : 5'd0;
		if (!wr) val = '0;
	end

	// control state: stage valid, result valid, pc, register valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
			pc_q      <= '0;
			rvalid_q  <= '0;
		end else begin
			if (acc) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (start_address_we) pc_q <= start_address;
			else if (adv) pc_q <= npc;
			if (adv && wr && rd != 5'd0) rvalid_q[rd] <= 1'b1;
		end
	end

	// register file write
	always_ff @(posedge clk) begin
		if (adv && wr && rd != 5'd0) regs[rd] <= val;
	end

	// operand read with forwarding of the instruction retiring this cycle
	always_ff @(posedge clk) begin
		if (acc) begin
			instr_s1 <= instr_word;
			load_s1  <= load_word;
			if (instr_word[19:15] == 5'd0) a_s1 <= '0;
			else if (adv && wr && rd == instr_word[19:15]) a_s1 <= val;
			else if (!rvalid_q[instr_word[19:15]]) a_s1 <= '0;
			else a_s1 <= regs[instr_word[19:15]];
			if (instr_word[24:20] == 5'd0) b_s1 <= '0;
			else if (adv && wr && rd == instr_word[24:20]) b_s1 <= val;
			else if (!rvalid_q[instr_word[24:20]]) b_s1 <= '0;
			else b_s1 <= regs[instr_word[24:20]];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv) begin
			next_pc      <= npc;
			mem_read     <= mrd;
			mem_write    <= mwr;
			mem_addr     <= maddr;
			mem_size     <= msize;
			store_word   <= sword;
			reg_write    <= wr;
			reg_index    <= rd;
			reg_value    <= val;
			bad_encoding <= bad;
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for rv32i_instruction_executor_unit
// Drives instruction words with random gaps, predicts each result word from an
// in-bench model of pc and register file, and compares every field in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	// exec result word as predicted
	typedef struct packed {
		logic [31:0] npc;
		logic        rd_en;
		logic        wr_en;
		logic [31:0] addr;
		logic [1:0]  size;
		logic [31:0] sdata;
		logic        rf_we;
		logic [4:0]  rf_idx;
		logic [31:0] rf_val;
		logic        bad;
	} exec_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start_address_we = 1'b0;
	logic [31:0] start_address = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] instr_word = '0;
	logic [31:0] load_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [31:0] next_pc, mem_addr, store_word, reg_value;
	logic        mem_read, mem_write, reg_write, bad_encoding;
	logic [1:0]  mem_size;
	logic [4:0]  reg_index;

	rv32i_instruction_executor_unit dut (
		.clk(clk), .arst_n(arst_n),
		.start_address_we(start_address_we), .start_address(start_address),
		.in_valid(in_valid), .in_stall(in_stall),
		.instr_word(instr_word), .load_word(load_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.next_pc(next_pc), .mem_read(mem_read), .mem_write(mem_write),
		.mem_addr(mem_addr), .mem_size(mem_size), .store_word(store_word),
		.reg_write(reg_write), .reg_index(reg_index), .reg_value(reg_value),
		.bad_encoding(bad_encoding)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0]  pc_model;
	logic [31:0]  gpr_model [32];
	exec_result_t pending_results [$];

	int  n_fail = 0;
	int  n_words = 0;
	int  n_results = 0;
	int  idle_cycles = 0;
	bit  hold_rx = 1'b0;  // long receiver hold-off request
	int  hold_len = 0;

	function automatic logic [31:0] gpr(input logic [4:0] idx);
		return (idx == 5'd0) ? 32'd0 : gpr_model[idx];
	endfunction

	// executes one instruction against the model state, returns the result word
	function automatic exec_result_t execute_instr(input logic [31:0] ins,
			input logic [31:0] ld);
		exec_result_t r;
		logic [6:0]  opc, f7;
		logic [2:0]  f3;
		logic [4:0]  rd, sh;
		logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, seq;
		logic        take;
		opc   = ins[6:0];
		rd    = ins[11:7];
		f3    = ins[14:12];
		f7    = ins[31:25];
		a     = gpr(ins[19:15]);
		b     = gpr(ins[24:20]);
		sh    = ins[24:20];
		imm_i = {{20{ins[31]}}, ins[31:20]};
		imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
		imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
		imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
		seq   = pc_model + rvx_pkg::PC_STEP;
		r     = '0;
		r.npc = seq;
		take  = 1'b0;
		case (opc)
			rvx_pkg::OP_BRANCH: begin
				case (f3)
					rvx_pkg::F3_BEQ:  take = (a == b);
					rvx_pkg::F3_BNE:  take = (a != b);
					rvx_pkg::F3_BLT:  take = ($signed(a) < $signed(b));
					rvx_pkg::F3_BGE:  take = !($signed(a) < $signed(b));
					rvx_pkg::F3_BLTU: take = (a < b);
					rvx_pkg::F3_BGEU: take = (a >= b);
					default: r.bad = 1'b1;
				endcase
				if (take) r.npc = pc_model + imm_b;
			end
			rvx_pkg::OP_JAL: begin
				r.npc = pc_model + imm_j; r.rf_we = 1'b1; r.rf_val = seq;
			end
			rvx_pkg::OP_JALR: begin
				if (f3 != 3'd0) r.bad = 1'b1;
				else begin
					r.npc = (a + imm_i) & rvx_pkg::JALR_MASK; r.rf_we = 1'b1;
					r.rf_val = seq;
				end
			end
			rvx_pkg::OP_LOAD: begin
				r.addr = a + imm_i; r.rd_en = 1'b1; r.rf_we = 1'b1;
				case (f3)
					rvx_pkg::F3_LB: begin
						r.size = rvx_pkg::SIZE_BYTE; r.rf_val = {{24{ld[7]}}, ld[7:0]};
					end
					rvx_pkg::F3_LH: begin
						r.size = rvx_pkg::SIZE_HALF; r.rf_val = {{16{ld[15]}}, ld[15:0]};
					end
					rvx_pkg::F3_LW: begin
						r.size = rvx_pkg::SIZE_WORD; r.rf_val = ld;
					end
					rvx_pkg::F3_LBU: begin
						r.size = rvx_pkg::SIZE_BYTE; r.rf_val = {24'd0, ld[7:0]};
					end
					rvx_pkg::F3_LHU: begin
						r.size = rvx_pkg::SIZE_HALF; r.rf_val = {16'd0, ld[15:0]};
					end
					default: r.bad = 1'b1;
				endcase
			end
			rvx_pkg::OP_STORE: begin
				if (f3 > 3'd2) r.bad = 1'b1;
				else begin
					r.addr = a + imm_s; r.wr_en = 1'b1; r.size = f3[1:0]; r.sdata = b;
				end
			end
			rvx_pkg::OP_REG: begin
				r.rf_we = 1'b1;
				if (f7 == rvx_pkg::F7_NORM) begin
					case (f3)
						rvx_pkg::F3_ADD:  r.rf_val = a + b;
						rvx_pkg::F3_SLL:  r.rf_val = a << b[4:0];
						rvx_pkg::F3_SLT:  r.rf_val = {31'd0, $signed(a) < $signed(b)};
						rvx_pkg::F3_SLTU: r.rf_val = {31'd0, a < b};
						rvx_pkg::F3_XOR:  r.rf_val = a ^ b;
						rvx_pkg::F3_SR:   r.rf_val = a >> b[4:0];
						rvx_pkg::F3_OR:   r.rf_val = a | b;
						default:          r.rf_val = a & b;
					endcase
				end else if (f7 == rvx_pkg::F7_ALT && f3 == rvx_pkg::F3_ADD) r.rf_val = a - b;
				else if (f7 == rvx_pkg::F7_ALT && f3 == rvx_pkg::F3_SR)
					r.rf_val = $unsigned($signed(a) >>> b[4:0]);
				else r.bad = 1'b1;
			end
			rvx_pkg::OP_IMM: begin
				r.rf_we = 1'b1;
				case (f3)
					rvx_pkg::F3_ADD:  r.rf_val = a + imm_i;
					rvx_pkg::F3_SLL: begin
						if (f7 == rvx_pkg::F7_NORM) r.rf_val = a << sh;
						else r.bad = 1'b1;
					end
					rvx_pkg::F3_SLT:  r.rf_val = {31'd0, $signed(a) < $signed(imm_i)};
					rvx_pkg::F3_SLTU: r.rf_val = {31'd0, a < imm_i};
					rvx_pkg::F3_XOR:  r.rf_val = a ^ imm_i;
					rvx_pkg::F3_SR: begin
						if (f7 == rvx_pkg::F7_NORM) r.rf_val = a >> sh;
						else if (f7 == rvx_pkg::F7_ALT) r.rf_val = $unsigned($signed(a) >>> sh);
						else r.bad = 1'b1;
					end
					rvx_pkg::F3_OR:   r.rf_val = a | imm_i;
					default:          r.rf_val = a & imm_i;
				endcase
			end
			rvx_pkg::OP_LUI: begin
				r.rf_we = 1'b1; r.rf_val = {ins[31:12], 12'd0};
			end
			rvx_pkg::OP_AUIPC: begin
				r.rf_we = 1'b1; r.rf_val = pc_model + {ins[31:12], 12'd0};
			end
			default:  r.bad = 1'b1;
		endcase
		if (r.bad) begin
			r = '0; r.bad = 1'b1; r.npc = pc_model;
		end
		if (r.rf_we) r.rf_idx = rd;
		// commit to model; x0 never changes
		if (r.rf_we && rd != 5'd0) gpr_model[rd] = r.rf_val;
		pc_model = r.npc;
		return r;
	endfunction

	// sends one word after a random gap, predicting at accept;
	// valid stays high afterwards until the next gap or drop_valid
	task automatic send_word(input logic [31:0] ins, input logic [31:0] ld);
		int gap;
		exec_result_t r;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		if ($urandom_range(0, 1)) gap = 0;  // stretches with no gaps
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		instr_word <= ins;
		load_word  <= ld;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = execute_instr(ins, ld);
		pending_results = {pending_results, r};
		n_words++;
		@(negedge clk);
	endtask

	// sender goes idle at the current falling edge
	task automatic drop_valid();
		in_valid <= 1'b0;
	endtask

	// register write happens only with nothing in flight
	task automatic write_start(input logic [31:0] addr);
		drop_valid();
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		start_address_we <= 1'b1;
		start_address    <= addr;
		@(negedge clk);
		start_address_we <= 1'b0;
		pc_model = addr;
	endtask

	// instruction builders
	function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd,
			input logic [6:0] opc);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
			input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] opc);
		return {imm, rs1, f3, rd, opc};
	endfunction

	// legal opcode with random fields (funct fields may still be illegal); small registers often reused
	function automatic logic [31:0] rand_instr();
		logic [31:0] w;
		logic [6:0]  ops [9];
		w = $urandom;
		ops = '{rvx_pkg::OP_BRANCH, rvx_pkg::OP_JAL, rvx_pkg::OP_JALR, rvx_pkg::OP_LOAD,
			rvx_pkg::OP_STORE, rvx_pkg::OP_REG, rvx_pkg::OP_IMM, rvx_pkg::OP_LUI,
			rvx_pkg::OP_AUIPC};
		w[6:0] = ops[$urandom_range(0, 8)];
		if ($urandom_range(0, 1)) begin
			w[11:7]  = 5'($urandom_range(0, 7));
			w[19:15] = 5'($urandom_range(0, 7));
			w[24:20] = 5'($urandom_range(0, 7));
		end
		case (w[6:0])
			rvx_pkg::OP_REG:
				w[31:25] = ($urandom_range(0, 3) == 0) ? rvx_pkg::F7_ALT : rvx_pkg::F7_NORM;
			rvx_pkg::OP_IMM: if (w[14:12] == rvx_pkg::F3_SLL || w[14:12] == rvx_pkg::F3_SR)
				w[31:25] = ($urandom_range(0, 1)) ? rvx_pkg::F7_ALT : rvx_pkg::F7_NORM;
			rvx_pkg::OP_JALR: w[14:12] = 3'd0;
			default: ;
		endcase
		return w;
	endfunction

	// ---------------- tests ----------------
	task automatic test_directed();
		logic [31:0] ld;
		ld = 32'hFFFF_8080;
		// load extremes into registers
		send_word({20'hFFFFF, 5'd1, rvx_pkg::OP_LUI}, '0);
		send_word(enc_i(12'hFFF, 5'd1, rvx_pkg::F3_ADD, 5'd1, rvx_pkg::OP_IMM), '0);
		send_word({20'h80000, 5'd2, rvx_pkg::OP_LUI}, '0);
		send_word(enc_i(12'h7FF, 5'd0, rvx_pkg::F3_ADD, 5'd3, rvx_pkg::OP_IMM), '0);
		send_word(enc_i(12'h000, 5'd0, rvx_pkg::F3_ADD, 5'd0, rvx_pkg::OP_IMM), '0);  // x0
		send_word(enc_r(rvx_pkg::F7_ALT, 5'd3, 5'd2, rvx_pkg::F3_SR, 5'd4,
			rvx_pkg::OP_REG), '0);
		send_word(enc_r(rvx_pkg::F7_ALT, 5'd1, 5'd2, rvx_pkg::F3_ADD, 5'd5,
			rvx_pkg::OP_REG), '0);
		send_word(enc_r(rvx_pkg::F7_NORM, 5'd1, 5'd2, rvx_pkg::F3_SLT, 5'd6,
			rvx_pkg::OP_REG), '0);
		send_word(enc_r(rvx_pkg::F7_NORM, 5'd1, 5'd2, rvx_pkg::F3_SLTU, 5'd6,
			rvx_pkg::OP_REG), '0);
		send_word(enc_i({rvx_pkg::F7_ALT, 5'd31}, 5'd2, rvx_pkg::F3_SR, 5'd7,
			rvx_pkg::OP_IMM), '0);
		// loads with each extension, upper bits of load data set
		send_word(enc_i(12'h800, 5'd1, rvx_pkg::F3_LB, 5'd8, rvx_pkg::OP_LOAD), ld);
		send_word(enc_i(12'h7FF, 5'd2, rvx_pkg::F3_LH, 5'd8, rvx_pkg::OP_LOAD), ld);
		send_word(enc_i(12'h004, 5'd0, rvx_pkg::F3_LW, 5'd8, rvx_pkg::OP_LOAD),
			32'hFFFF_FFFF);
		send_word(enc_i(12'h000, 5'd1, rvx_pkg::F3_LBU, 5'd8, rvx_pkg::OP_LOAD), ld);
		send_word(enc_i(12'h000, 5'd1, rvx_pkg::F3_LHU, 5'd9, rvx_pkg::OP_LOAD), ld);
		send_word({7'h7F, 5'd1, 5'd2, 3'd2, 5'h1F, rvx_pkg::OP_STORE}, '0);
		send_word({7'h00, 5'd1, 5'd2, 3'd0, 5'h00, rvx_pkg::OP_STORE}, '0);
		// two branches (neither taken), jumps, misaligned JALR target
		send_word({1'b1, 6'h3F, 5'd2, 5'd1, rvx_pkg::F3_BLT, 4'hE, 1'b1,
			rvx_pkg::OP_BRANCH}, '0);
		send_word({1'b0, 6'h00, 5'd2, 5'd1, rvx_pkg::F3_BLTU, 4'h2, 1'b0,
			rvx_pkg::OP_BRANCH}, '0);
		send_word({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd10, rvx_pkg::OP_JAL}, '0);
		send_word(enc_i(12'h7FF, 5'd1, 3'd0, 5'd11, rvx_pkg::OP_JALR), '0);
		send_word({20'hFFFFF, 5'd12, rvx_pkg::OP_AUIPC}, '0);
		// bad encodings: fence, ecall, bad funct3 / funct7
		send_word(32'h0000_000F, '0);
		send_word(32'h0000_0073, '0);
		send_word(enc_r(7'h01, 5'd1, 5'd2, rvx_pkg::F3_ADD, 5'd13, rvx_pkg::OP_REG), '0);
		send_word({7'd0, 5'd1, 5'd2, 3'd2, 5'd0, rvx_pkg::OP_BRANCH}, '0);
	endtask

	task automatic test_random(input int n);
		logic [31:0] w;
		for (int i = 0; i < n; i++) begin
			// mostly legal words; some raw noise for bad encodings
			w = ($urandom_range(0, 9) == 0) ? $urandom : rand_instr();
			send_word(w, $urandom);
		end
	endtask

	// receiver holds off while sender keeps offering words
	task automatic test_backpressure();
		hold_len = 60;
		hold_rx  = 1'b1;
		test_random(40);
		// sender pause until everything has drained
		drop_valid();
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic test_start_address();
		logic [31:0] addrs [3];
		addrs = '{32'hFFFF_FFFC, 32'h0000_0000, 32'h8000_0000};
		foreach (addrs[k]) begin
			write_start(addrs[k]);
			test_random(150);
		end
		write_start($urandom & 32'hFFFF_FFFC);
	endtask

	// ---------------- receiver ----------------
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(negedge clk);
				hold_rx = 1'b0;
			end
			wait_n = ($urandom_range(0, 1)) ? 0 : $urandom_range(0, 15);
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// ---------------- result check ----------------
	always @(posedge clk) begin
		exec_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				n_fail++;
			end else begin
				e = pending_results.pop_front();
				if (next_pc !== e.npc) begin
					$error("next_pc exp %h got %h", e.npc, next_pc); n_fail++; end
				if (mem_read !== e.rd_en) begin
					$error("mem_read exp %b got %b", e.rd_en, mem_read); n_fail++; end
				if (mem_write !== e.wr_en) begin
					$error("mem_write exp %b got %b", e.wr_en, mem_write); n_fail++; end
				if (mem_addr !== e.addr) begin
					$error("mem_addr exp %h got %h", e.addr, mem_addr); n_fail++; end
				if (mem_size !== e.size) begin
					$error("mem_size exp %0d got %0d", e.size, mem_size); n_fail++; end
				if (store_word !== e.sdata) begin
					$error("store_word exp %h got %h", e.sdata, store_word); n_fail++; end
				if (reg_write !== e.rf_we) begin
					$error("reg_write exp %b got %b", e.rf_we, reg_write); n_fail++; end
				if (reg_index !== e.rf_idx) begin
					$error("reg_index exp %0d got %0d", e.rf_idx, reg_index); n_fail++; end
				if (reg_value !== e.rf_val) begin
					$error("reg_value exp %h got %h", e.rf_val, reg_value); n_fail++; end
				if (bad_encoding !== e.bad) begin
					$error("bad_encoding exp %b got %b", e.bad, bad_encoding); n_fail++; end
			end
		end
	end

	// watchdog: cycles without any accepted word on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("watchdog expired");
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------- sequence ----------------
	initial begin
		pc_model = '0;
		foreach (gpr_model[k]) gpr_model[k] = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random(1300);
		test_start_address();
		test_random(100);
		drop_valid();
		while (pending_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		$display("covered %0d instruction words, %0d result words checked", n_words,
			n_results);
		$display("all opcodes, load extensions, bad encodings, start address extremes");
		if (n_fail == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: rv32i_instruction_executor_unit.f
sv/rvx_pkg.sv
sv/rv32i_instruction_executor_unit.sv
tb/sv/tb.sv
